@@ src/upc_pkg.sv @@
// upc_pkg: types, codes and helpers shared by the udp pseudo-header checksum block
// no dependencies
package upc_pkg;

    localparam logic       OP_ADDR     = 1'b0;
    localparam logic       OP_DATA     = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN      = 2'd1;
    localparam logic [1:0] ST_ADDR     = 2'd2;

    localparam logic [15:0] PROTO_WORD = 16'h0011;
    localparam logic [15:0] SUM_MASK   = 16'hffff;
    localparam logic [16:0] LEN_LIMIT  = 17'h10000;
    localparam logic [5:0]  ADDR_MAX   = 6'd63;
    localparam logic [5:0]  ADDR_V4    = 6'd8;
    localparam logic [5:0]  ADDR_V6    = 6'd32;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [15:0] checksum;
        logic [15:0] datagram_length;
        logic [1:0]  status;
    } t_out_item;

    function automatic logic [15:0] add_eac(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = 17'(a) + 17'(b);
        return s[15:0] + 16'(s[16]);
    endfunction

endpackage

@@ src/upc_if.sv @@
// upc_in_if / upc_out_if: valid-ready request channels of the checksum block
// depends on upc_pkg
interface upc_in_if import upc_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface upc_out_if import upc_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/upc_in_reg.sv @@
// upc_in_reg: input register stage of the checksum block
// depends on upc_pkg
module upc_in_reg import upc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_in_item o_item
);

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (o_ready) begin
            n_valid = i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

@@ src/upc_accum.sv @@
// upc_accum: running one's complement sum, byte counters and result register
// depends on upc_pkg
module upc_accum import upc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_result
);

    logic [15:0] r_sum;
    logic [7:0]  r_pend_byte;
    logic        r_pend_valid;
    logic [16:0] r_byte_cnt;
    logic [5:0]  r_addr_cnt;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [15:0] n_sum;
    logic [7:0]  n_pend_byte;
    logic        n_pend_valid;
    logic [16:0] n_byte_cnt;
    logic [5:0]  n_addr_cnt;
    logic        n_out_valid;

    logic        adv;
    logic [15:0] word;
    logic [15:0] len16;
    logic [17:0] total;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [1:0]  status;
    logic [16:0] cnt_upd;
    logic [5:0]  addr_upd;

    assign o_ready  = !r_out_valid || i_ready;
    assign adv      = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        word     = r_pend_valid ? {r_pend_byte, i_item.data_byte} : {i_item.data_byte, 8'h00};
        cnt_upd  = r_byte_cnt;
        addr_upd = r_addr_cnt;
        if (i_item.operation == OP_DATA) begin
            if (r_byte_cnt != LEN_LIMIT) begin
                cnt_upd = r_byte_cnt + 17'd1;
            end
        end else begin
            if (r_addr_cnt != ADDR_MAX) begin
                addr_upd = r_addr_cnt + 6'd1;
            end
        end
        len16  = cnt_upd[16] ? SUM_MASK : cnt_upd[15:0];
        total  = 18'(r_sum) + 18'(word) + 18'(PROTO_WORD) + 18'(len16);
        fold1  = 17'(total[15:0]) + 17'(total[17:16]);
        fold2  = fold1[15:0] + 16'(fold1[16]);
        if (addr_upd != ADDR_V4 && addr_upd != ADDR_V6) begin
            status = ST_ADDR;
        end else if (cnt_upd[16]) begin
            status = ST_LEN;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        n_sum        = r_sum;
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        n_byte_cnt   = r_byte_cnt;
        n_addr_cnt   = r_addr_cnt;
        n_out_valid  = r_out_valid && !i_ready;
        if (adv) begin
            if (i_item.last) begin
                n_sum        = '0;
                n_pend_byte  = '0;
                n_pend_valid = 1'b0;
                n_byte_cnt   = '0;
                n_addr_cnt   = '0;
                n_out_valid  = 1'b1;
            end else begin
                n_byte_cnt = cnt_upd;
                n_addr_cnt = addr_upd;
                if (r_pend_valid) begin
                    n_sum        = add_eac(r_sum, word);
                    n_pend_byte  = '0;
                    n_pend_valid = 1'b0;
                end else begin
                    n_pend_byte  = i_item.data_byte;
                    n_pend_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_pend_byte  <= '0;
            r_pend_valid <= 1'b0;
            r_byte_cnt   <= '0;
            r_addr_cnt   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_sum        <= n_sum;
            r_pend_byte  <= n_pend_byte;
            r_pend_valid <= n_pend_valid;
            r_byte_cnt   <= n_byte_cnt;
            r_addr_cnt   <= n_addr_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_item.last) begin
            r_out.checksum        <= ~fold2;
            r_out.datagram_length <= len16;
            r_out.status          <= status;
        end
    end

endmodule

@@ src/udp_pseudo_header_checksum.sv @@
// udp_pseudo_header_checksum: top level, input register feeding the checksum accumulator
// depends on upc_pkg, upc_if, upc_in_reg, upc_accum
//
// Takes one byte request per clock, address bytes of the pseudo-header first, then the
// datagram bytes with the checksum field zero. Bytes pair big-endian into 16-bit words
// added with end-around carry. The byte marked last closes the packet. A result request
// carries the inverted sum, the saturated datagram length and a status. It becomes valid
// after that byte is accepted: the byte sits in the input register, and the accumulator
// then loads the result register. The state starts over for the next packet at once.
// While a result is held and not taken, the accumulator takes no byte; once the input
// register holds one, the input stalls too. Otherwise a byte is taken every clock.
// A zero checksum is sent as zero.
module udp_pseudo_header_checksum import upc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    upc_in_if.sink    i_in,
    upc_out_if.source o_res
);

    logic     s_valid;
    logic     s_ready;
    t_in_item s_item;

    upc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_item  (i_in.data),
        .o_valid (s_valid),
        .i_ready (s_ready),
        .o_item  (s_item)
    );

    upc_accum u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_valid),
        .o_ready  (s_ready),
        .i_item   (s_item),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (o_res.data)
    );

endmodule

@@ src/upc_checker.sv @@
// upc_checker: port-level assertions for udp_pseudo_header_checksum, bound to the top level
// depends on upc_pkg
module upc_checker import upc_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_checksum,
    input logic [15:0] i_length,
    input logic [1:0]  i_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_checksum) && $stable(i_length) && $stable(i_status))
        else $error("result payload changed while stalled");

    a_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_LEN |-> i_length == SUM_MASK)
        else $error("length error without saturated length");

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result request right after reset");

endmodule

bind udp_pseudo_header_checksum upc_checker u_upc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_checksum  (o_res.data.checksum),
    .i_length    (o_res.data.datagram_length),
    .i_status    (o_res.data.status)
);
